/* hw/rtl/laplacian_stencil_3d_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Laplacian stencil block
// Short forms for same-cycle and next-cycle implications on one clock with a
// synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_STENCIL_3D_TOP_MACROS_SVH
`define LAPLACIAN_STENCIL_3D_TOP_MACROS_SVH

// Check cons in the same cycle as ante
`define LSD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante
`define LSD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lsd_pkg.sv */
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared widths, codes and defaults of the 3D Laplacian stencil block.
// ----------------------------------------------------------------------------
package lsd_pkg;

    // Default grid limits
    localparam int DEF_MAX_X = 64;
    localparam int DEF_MAX_Y = 32;
    localparam int DEF_MAX_Z = 32;

    // Field widths
    localparam int X_POS_W  = 6;
    localparam int Y_POS_W  = 5;
    localparam int Z_POS_W  = 5;
    localparam int SAMPLE_W = 32;
    localparam int LAP_W    = 32;
    localparam int S_DATA_W = X_POS_W + Y_POS_W + Z_POS_W + SAMPLE_W;
    localparam int M_DATA_W = LAP_W;
    localparam int M_USER_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int X_EXT_W    = 7;
    localparam int Y_EXT_W    = 6;
    localparam int Z_EXT_W    = 6;
    localparam int WEIGHT_W   = 32;

    // Extent compare width, covers limits up to 1024
    localparam int EXT_W = 11;

    // Arithmetic widths
    localparam int SUM_W  = SAMPLE_W + 1;            // two neighbors
    localparam int DIFF_W = SAMPLE_W + 3;            // next + prev - 2*center
    localparam int HALF_W = WEIGHT_W / 2;
    localparam int PROD_W = DIFF_W + HALF_W + 1;     // times unsigned half weight
    localparam int ACC_W  = PROD_W + 2;              // sum of three axes
    localparam int RES_W  = ACC_W + 1;               // hi + lo/2^16

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_EXTENT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_EXTENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_EXTENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX_SQ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DY_SQ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DZ_SQ = 3'd5;

    // Register reset values
    localparam logic [X_EXT_W-1:0]  RST_X_EXTENT = 7'd64;
    localparam logic [Y_EXT_W-1:0]  RST_Y_EXTENT = 6'd32;
    localparam logic [Z_EXT_W-1:0]  RST_Z_EXTENT = 6'd32;
    localparam logic [WEIGHT_W-1:0] RST_INV_SQ   = 32'h0100_0000;

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Saturation limits
    localparam logic [LAP_W-1:0] LAP_MAX = 32'h7FFF_FFFF;
    localparam logic [LAP_W-1:0] LAP_MIN = 32'h8000_0000;

endpackage

/* hw/rtl/lsd_ram.sv */
// ----------------------------------------------------------------------------
// lsd_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, always register the read word
    always_ff @(posedge clk) begin
        if (we) begin
            mem_array[addr] <= wdata;
        end
        rdata_reg <= mem_array[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/laplacian_stencil_3d_top.sv */
// ----------------------------------------------------------------------------
// laplacian_stencil_3d_top
// Stores a 3D grid of Q16.16 samples and answers seven-point Laplacian
// queries on it, weighted per axis, truncated and saturated to Q16.16.
//
//   channel | dir | beat contents
//   --------+-----+------------------------------------------------------
//   s_      | in  | tuser: req_type; tdata: x_pos, y_pos, z_pos, sample
//   m_      | out | tdata: laplacian; tuser: saturated, bad_position
//   cfg_    | in  | cfg_index, cfg_wdata; one register per write
//
// An interior query keeps s_tready low from accept until idle again: the
// seven stencil words are read one per cycle through the single grid RAM
// port, then one shared multiplier pair handles one axis per cycle.
// An in-range write gives no result; other non-interior items return zero.
// Reset initialises control and configuration; grid contents stay undefined.
// While an earlier result waits, the sequencer holds in its final state.
// ----------------------------------------------------------------------------
`include "laplacian_stencil_3d_top_macros.svh"

module laplacian_stencil_3d_top #(
    parameter int MAX_X = lsd_pkg::DEF_MAX_X,
    parameter int MAX_Y = lsd_pkg::DEF_MAX_Y,
    parameter int MAX_Z = lsd_pkg::DEF_MAX_Z
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input beats
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // x_pos[5:0], y_pos[10:6], z_pos[15:11], sample[47:16]
    input  logic [lsd_pkg::S_DATA_W-1:0]    s_tdata,
    // req_type[0]
    input  logic                            s_tuser,
    // result beats
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // laplacian[31:0]
    output logic [lsd_pkg::M_DATA_W-1:0]    m_tdata,
    // saturated[0], bad_position[1]
    output logic [lsd_pkg::M_USER_W-1:0]    m_tuser,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [lsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lsd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import lsd_pkg::*;

    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0]    STRIDE_X = AW'(MAX_Y * MAX_Z);
    localparam logic [AW-1:0]    STRIDE_Y = AW'(MAX_Z);
    localparam logic [AW-1:0]    STRIDE_Z = AW'(1);
    localparam logic [EXT_W-1:0] LIM_X    = EXT_W'(MAX_X);
    localparam logic [EXT_W-1:0] LIM_Y    = EXT_W'(MAX_Y);
    localparam logic [EXT_W-1:0] LIM_Z    = EXT_W'(MAX_Z);

    // Stencil read order
    localparam logic [2:0] NB_CENTER = 3'd0;
    localparam logic [2:0] NB_XP     = 3'd1;
    localparam logic [2:0] NB_XM     = 3'd2;
    localparam logic [2:0] NB_YP     = 3'd3;
    localparam logic [2:0] NB_YM     = 3'd4;
    localparam logic [2:0] NB_ZP     = 3'd5;
    localparam logic [2:0] NB_ZM     = 3'd6;

    // Axis steps of the multiplier
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_READ   = 8'b0000_0100,
        S_DRAIN  = 8'b0000_1000,
        S_DIFF   = 8'b0001_0000,
        S_MUL    = 8'b0010_0000,
        S_ACC    = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [X_EXT_W-1:0]         x_ext_reg;
    logic [Y_EXT_W-1:0]         y_ext_reg;
    logic [Z_EXT_W-1:0]         z_ext_reg;
    logic [WEIGHT_W-1:0]        inv_dx_reg, inv_dy_reg, inv_dz_reg;

    logic                       kind_reg;
    logic [X_POS_W-1:0]         x_reg;
    logic [Y_POS_W-1:0]         y_reg;
    logic [Z_POS_W-1:0]         z_reg;
    logic [SAMPLE_W-1:0]        sample_reg;

    logic                       zero_reg, zero_next;
    logic                       bad_reg, bad_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic [2:0]                 rd_cnt_reg, rd_cnt_next;
    logic                       rd_vld_reg;
    logic [2:0]                 rd_idx_reg;
    logic [1:0]                 mul_cnt_reg, mul_cnt_next;
    logic                       p_vld_reg;

    logic signed [SAMPLE_W-1:0] center_reg;
    logic signed [SUM_W-1:0]    sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [DIFF_W-1:0]   d_reg [3];
    logic signed [PROD_W-1:0]   prod_hi_reg, prod_lo_reg;
    logic signed [ACC_W-1:0]    hi_acc_reg, lo_acc_reg;

    logic                       m_tvalid_reg;
    logic [M_DATA_W-1:0]        m_tdata_reg;
    logic [M_USER_W-1:0]        m_tuser_reg;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic                       s_accept;
    logic [EXT_W-1:0]           ex, ey, ez;
    logic                       in_range, interior;
    logic [AW-1:0]              center_addr, nb_addr;
    logic                       ram_we;
    logic [AW-1:0]              ram_addr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SUM_W-1:0]    rd_word;
    logic signed [DIFF_W-1:0]   d_sel;
    logic [WEIGHT_W-1:0]        w_sel;
    logic signed [PROD_W-1:0]   prod_hi, prod_lo;
    logic signed [RES_W-1:0]    res_full;
    logic                       res_pos_ovf, res_neg_ovf;
    logic [LAP_W-1:0]           res_lap;
    logic                       res_sat;
    logic                       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_ext_reg  <= RST_X_EXTENT;
            y_ext_reg  <= RST_Y_EXTENT;
            z_ext_reg  <= RST_Z_EXTENT;
            inv_dx_reg <= RST_INV_SQ;
            inv_dy_reg <= RST_INV_SQ;
            inv_dz_reg <= RST_INV_SQ;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_X_EXTENT:  x_ext_reg  <= cfg_wdata[X_EXT_W-1:0];
                CFG_Y_EXTENT:  y_ext_reg  <= cfg_wdata[Y_EXT_W-1:0];
                CFG_Z_EXTENT:  z_ext_reg  <= cfg_wdata[Z_EXT_W-1:0];
                CFG_INV_DX_SQ: inv_dx_reg <= cfg_wdata;
                CFG_INV_DY_SQ: inv_dy_reg <= cfg_wdata;
                CFG_INV_DZ_SQ: inv_dz_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Capture the input beat
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg   <= s_tuser;
            x_reg      <= s_tdata[X_POS_W-1:0];
            y_reg      <= s_tdata[X_POS_W +: Y_POS_W];
            z_reg      <= s_tdata[X_POS_W+Y_POS_W +: Z_POS_W];
            sample_reg <= s_tdata[X_POS_W+Y_POS_W+Z_POS_W +: SAMPLE_W];
        end
    end

    // ------------------------------------------------------------------
    // Clamp extents, classify the position, form the center address
    // ------------------------------------------------------------------
    always_comb begin
        ex = (EXT_W'(x_ext_reg) > LIM_X) ? LIM_X : EXT_W'(x_ext_reg);
        ey = (EXT_W'(y_ext_reg) > LIM_Y) ? LIM_Y : EXT_W'(y_ext_reg);
        ez = (EXT_W'(z_ext_reg) > LIM_Z) ? LIM_Z : EXT_W'(z_ext_reg);
        in_range = (EXT_W'(x_reg) < ex) && (EXT_W'(y_reg) < ey) && (EXT_W'(z_reg) < ez);
        interior = (x_reg != '0) && (y_reg != '0) && (z_reg != '0)
                && (EXT_W'(x_reg) + EXT_W'(2) <= ex)
                && (EXT_W'(y_reg) + EXT_W'(2) <= ey)
                && (EXT_W'(z_reg) + EXT_W'(2) <= ez);
        center_addr = AW'(AW'(x_reg) * STRIDE_X) + AW'(AW'(y_reg) * STRIDE_Y)
                    + AW'(z_reg);
    end

    // Step through the stencil neighbors
    always_comb begin
        case (rd_cnt_reg)
            NB_XP:   nb_addr = addr_reg + STRIDE_X;
            NB_XM:   nb_addr = addr_reg - STRIDE_X;
            NB_YP:   nb_addr = addr_reg + STRIDE_Y;
            NB_YM:   nb_addr = addr_reg - STRIDE_Y;
            NB_ZP:   nb_addr = addr_reg + STRIDE_Z;
            NB_ZM:   nb_addr = addr_reg - STRIDE_Z;
            default: nb_addr = addr_reg;
        endcase
    end

    // ------------------------------------------------------------------
    // Grid memory
    // ------------------------------------------------------------------
    assign ram_we   = (state_reg == S_DECODE) && in_range && (kind_reg == REQ_WRITE);
    assign ram_addr = (state_reg == S_DECODE) ? center_addr : nb_addr;

    lsd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        zero_next    = zero_reg;
        bad_next     = bad_reg;
        addr_next    = addr_reg;
        rd_cnt_next  = rd_cnt_reg;
        mul_cnt_next = mul_cnt_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                zero_next = 1'b1;
                bad_next  = 1'b0;
                if (!in_range) begin
                    bad_next   = 1'b1;
                    state_next = S_FIN;
                end else if (kind_reg == REQ_WRITE) begin
                    state_next = S_IDLE;
                end else if (!interior) begin
                    state_next = S_FIN;
                end else begin
                    zero_next   = 1'b0;
                    addr_next   = center_addr;
                    rd_cnt_next = NB_CENTER;
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                rd_cnt_next = rd_cnt_reg + 3'd1;
                if (rd_cnt_reg == NB_ZM) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_DIFF;
            end
            S_DIFF: begin
                mul_cnt_next = AX_X;
                state_next   = S_MUL;
            end
            S_MUL: begin
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == AX_Z) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            zero_reg    <= 1'b0;
            bad_reg     <= 1'b0;
            rd_cnt_reg  <= '0;
            mul_cnt_reg <= '0;
            rd_vld_reg  <= 1'b0;
            p_vld_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            zero_reg    <= zero_next;
            bad_reg     <= bad_next;
            rd_cnt_reg  <= rd_cnt_next;
            mul_cnt_reg <= mul_cnt_next;
            rd_vld_reg  <= (state_reg == S_READ);
            p_vld_reg   <= (state_reg == S_MUL);
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= addr_next;
        rd_idx_reg <= rd_cnt_reg;
    end

    // ------------------------------------------------------------------
    // Gather center and neighbor sums as read words return
    // ------------------------------------------------------------------
    assign rd_word = SUM_W'($signed(ram_rdata));

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            case (rd_idx_reg)
                NB_CENTER: center_reg <= $signed(ram_rdata);
                NB_XP:     sum_x_reg  <= rd_word;
                NB_XM:     sum_x_reg  <= sum_x_reg + rd_word;
                NB_YP:     sum_y_reg  <= rd_word;
                NB_YM:     sum_y_reg  <= sum_y_reg + rd_word;
                NB_ZP:     sum_z_reg  <= rd_word;
                default:   sum_z_reg  <= sum_z_reg + rd_word;
            endcase
        end
    end

    // Form the second differences
    always_ff @(posedge aclk) begin
        if (state_reg == S_DIFF) begin
            d_reg[AX_X] <= DIFF_W'(sum_x_reg) - (DIFF_W'(center_reg) <<< 1);
            d_reg[AX_Y] <= DIFF_W'(sum_y_reg) - (DIFF_W'(center_reg) <<< 1);
            d_reg[AX_Z] <= DIFF_W'(sum_z_reg) - (DIFF_W'(center_reg) <<< 1);
        end
    end

    // ------------------------------------------------------------------
    // Weight one axis per cycle, split weight into high and low halves
    // ------------------------------------------------------------------
    always_comb begin
        case (mul_cnt_reg)
            AX_X:    w_sel = inv_dx_reg;
            AX_Y:    w_sel = inv_dy_reg;
            default: w_sel = inv_dz_reg;
        endcase
    end

    assign d_sel   = d_reg[mul_cnt_reg];
    assign prod_hi = d_sel * $signed({1'b0, w_sel[WEIGHT_W-1:HALF_W]});
    assign prod_lo = d_sel * $signed({1'b0, w_sel[HALF_W-1:0]});

    always_ff @(posedge aclk) begin
        prod_hi_reg <= prod_hi;
        prod_lo_reg <= prod_lo;
    end

    // Clear before the first product, add each product as it lands
    always_ff @(posedge aclk) begin
        if (state_reg == S_DIFF) begin
            hi_acc_reg <= '0;
            lo_acc_reg <= '0;
        end else if (p_vld_reg) begin
            hi_acc_reg <= hi_acc_reg + ACC_W'(prod_hi_reg);
            lo_acc_reg <= lo_acc_reg + ACC_W'(prod_lo_reg);
        end
    end

    // ------------------------------------------------------------------
    // Floor to Q16.16 and saturate
    // ------------------------------------------------------------------
    always_comb begin
        res_full    = RES_W'(hi_acc_reg) + RES_W'(lo_acc_reg >>> HALF_W);
        res_pos_ovf = !res_full[RES_W-1] && (|res_full[RES_W-2:LAP_W-1]);
        res_neg_ovf = res_full[RES_W-1] && !(&res_full[RES_W-2:LAP_W-1]);
        res_sat     = res_pos_ovf || res_neg_ovf;
        if (res_pos_ovf) begin
            res_lap = LAP_MAX;
        end else if (res_neg_ovf) begin
            res_lap = LAP_MIN;
        end else begin
            res_lap = res_full[LAP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register: load in the final state, drop on accept
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_FIN && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN && out_free) begin
            m_tdata_reg <= zero_reg ? '0 : res_lap;
            m_tuser_reg <= {bad_reg, zero_reg ? 1'b0 : res_sat};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LSD_ASSERT_IMP(a_ram_we_decode, aclk, aresetn, ram_we,
        state_reg == S_DECODE && kind_reg == REQ_WRITE, "grid write outside decode")
    `LSD_ASSERT_IMP(a_rd_cnt_range, aclk, aresetn, state_reg == S_READ,
        rd_cnt_reg <= NB_ZM, "stencil read index past last neighbor")
    `LSD_ASSERT_IMP(a_out_from_fin, aclk, aresetn, $rose(m_tvalid_reg),
        $past(state_reg) == S_FIN, "result beat raised outside final state")
    `LSD_ASSERT_IMP(a_bad_is_zero, aclk, aresetn, m_tvalid_reg && m_tuser_reg[1],
        m_tdata_reg == '0 && !m_tuser_reg[0], "bad position beat carries a value")
    `LSD_ASSERT_IMP(a_sat_is_limit, aclk, aresetn, m_tvalid_reg && m_tuser_reg[0],
        m_tdata_reg == LAP_MAX || m_tdata_reg == LAP_MIN, "saturated beat not at a limit")

endmodule
